// ----- design/flps_pkg.sv -----
// Package for the fieldbus link phase supervisor.
// Holds the phase and event codes, register indexes, config and result types.
// No dependencies.
package flps_pkg;

	typedef enum logic [1:0] {
		PHASE_PRIME = 2'd0,
		PHASE_WAIT  = 2'd1,
		PHASE_LOCK  = 2'd2,
		PHASE_RUN   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_PRIME_DONE = 3'd1,
		EV_STABLE     = 3'd2,
		EV_LOCKED     = 3'd3,
		EV_LOCK_LOST  = 3'd4,
		EV_RUN_LOST   = 3'd5,
		EV_RUN_BAD    = 3'd6
	} event_t;

	typedef enum logic [2:0] {
		REG_PRIME_TICKS    = 3'd0,
		REG_CHECK_INTERVAL = 3'd1,
		REG_STABLE_NEEDED  = 3'd2,
		REG_LOCK_DELAY     = 3'd3,
		REG_BAD_LIMIT      = 3'd4,
		REG_RATIO_NUM      = 3'd5,
		REG_RATIO_DEN      = 3'd6,
		REG_SYNC_INTERVAL  = 3'd7
	} reg_idx_t;

	localparam logic [15:0] RST_PRIME_TICKS    = 16'd2000;
	localparam logic [15:0] RST_CHECK_INTERVAL = 16'd50;
	localparam logic [7:0]  RST_STABLE_NEEDED  = 8'd20;
	localparam logic [15:0] RST_LOCK_DELAY     = 16'd100;
	localparam logic [7:0]  RST_BAD_LIMIT      = 8'd3;
	localparam logic [7:0]  RST_RATIO_NUM      = 8'd9;
	localparam logic [7:0]  RST_RATIO_DEN      = 8'd10;
	localparam logic [7:0]  RST_SYNC_INTERVAL  = 8'd10;

	typedef struct packed {
		logic [15:0] prime_ticks;
		logic [15:0] check_interval;
		logic [7:0]  stable_checks_needed;
		logic [15:0] lock_delay_checks;
		logic [7:0]  bad_count_limit;
		logic [7:0]  ratio_numerator;
		logic [7:0]  ratio_denominator;
		logic [7:0]  run_sync_interval;
	} cfg_t;

	typedef struct packed {
		event_t      event_code;
		logic [15:0] locked_count;
		logic        check_tick;
		logic        sync_pulse;
		logic        motion_active;
		phase_t      phase_now;
	} result_t;

endpackage

// ----- design/flps_regs.sv -----
// Configuration register file of the fieldbus link phase supervisor.
// APB-style write and read access; depends on flps_pkg.
module flps_regs
	import flps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prime_ticks          <= RST_PRIME_TICKS;
			cfg_q.check_interval       <= RST_CHECK_INTERVAL;
			cfg_q.stable_checks_needed <= RST_STABLE_NEEDED;
			cfg_q.lock_delay_checks    <= RST_LOCK_DELAY;
			cfg_q.bad_count_limit      <= RST_BAD_LIMIT;
			cfg_q.ratio_numerator      <= RST_RATIO_NUM;
			cfg_q.ratio_denominator    <= RST_RATIO_DEN;
			cfg_q.run_sync_interval    <= RST_SYNC_INTERVAL;
		end else if (wr_en) begin
			unique case (idx)
				REG_PRIME_TICKS:    cfg_q.prime_ticks          <= pwdata[15:0];
				REG_CHECK_INTERVAL: cfg_q.check_interval       <= pwdata[15:0];
				REG_STABLE_NEEDED:  cfg_q.stable_checks_needed <= pwdata[7:0];
				REG_LOCK_DELAY:     cfg_q.lock_delay_checks    <= pwdata[15:0];
				REG_BAD_LIMIT:      cfg_q.bad_count_limit      <= pwdata[7:0];
				REG_RATIO_NUM:      cfg_q.ratio_numerator      <= pwdata[7:0];
				REG_RATIO_DEN:      cfg_q.ratio_denominator    <= pwdata[7:0];
				REG_SYNC_INTERVAL:  cfg_q.run_sync_interval    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PRIME_TICKS:    prdata = {16'd0, cfg_q.prime_ticks};
			REG_CHECK_INTERVAL: prdata = {16'd0, cfg_q.check_interval};
			REG_STABLE_NEEDED:  prdata = {24'd0, cfg_q.stable_checks_needed};
			REG_LOCK_DELAY:     prdata = {16'd0, cfg_q.lock_delay_checks};
			REG_BAD_LIMIT:      prdata = {24'd0, cfg_q.bad_count_limit};
			REG_RATIO_NUM:      prdata = {24'd0, cfg_q.ratio_numerator};
			REG_RATIO_DEN:      prdata = {24'd0, cfg_q.ratio_denominator};
			REG_SYNC_INTERVAL:  prdata = {24'd0, cfg_q.run_sync_interval};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

// ----- design/flps_core.sv -----
// Tick processing of the fieldbus link phase supervisor: counters, sync divider,
// working counter check and phase machine. Depends on flps_pkg.
module flps_core
	import flps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        ops,
	input  logic [15:0] wc,
	input  cfg_t        cfg,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [15:0] intv_q, intv_d;
	logic [7:0]  stable_q, stable_d;
	logic [15:0] lock_q, lock_d;
	logic [7:0]  bad_q, bad_d;
	logic [15:0] expect_q, expect_d;
	logic        motion_q, motion_d;
	logic [7:0]  sdiv_q, sdiv_d;
	logic [7:0]  sint_q, sint_d;

	logic [15:0] ci;
	logic [15:0] intv_inc;
	logic [8:0]  sdiv_inc;
	logic [23:0] lhs, rhs;
	logic        cnt_good, good, check, pulse;
	event_t      ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_PRIME;
			tick_q   <= 16'd0;
			intv_q   <= 16'd0;
			stable_q <= 8'd0;
			lock_q   <= 16'd0;
			bad_q    <= 8'd0;
			expect_q <= 16'd0;
			motion_q <= 1'b0;
			sdiv_q   <= RST_SYNC_INTERVAL;
			sint_q   <= RST_SYNC_INTERVAL;
		end else if (advance) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			intv_q   <= intv_d;
			stable_q <= stable_d;
			lock_q   <= lock_d;
			bad_q    <= bad_d;
			expect_q <= expect_d;
			motion_q <= motion_d;
			sdiv_q   <= sdiv_d;
			sint_q   <= sint_d;
		end
	end

	assign lhs      = 24'(wc) * 24'(cfg.ratio_denominator);
	assign rhs      = 24'(expect_q) * 24'(cfg.ratio_numerator);
	assign cnt_good = (expect_q == 16'd0) ? (wc != 16'd0) : (lhs >= rhs);
	assign good     = ops && cnt_good;

	always_comb begin
		phase_d  = phase_q;
		stable_d = stable_q;
		lock_d   = lock_q;
		bad_d    = bad_q;
		expect_d = expect_q;
		motion_d = motion_q;
		ev       = EV_NONE;

		tick_d   = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
		ci       = (cfg.check_interval == 16'd0) ? 16'd1 : cfg.check_interval;
		intv_inc = intv_q + 16'd1;
		check    = intv_inc >= ci;
		intv_d   = check ? 16'd0 : intv_inc;

		sdiv_inc = {1'b0, sdiv_q} + 9'd1;
		pulse    = sdiv_inc >= {1'b0, sint_q};
		sdiv_d   = pulse ? 8'd0 : sdiv_inc[7:0];
		sint_d   = motion_q ? cfg.run_sync_interval : 8'd1;

		if (check) begin
			unique case (phase_q)
				PHASE_PRIME: begin
					if (tick_d >= cfg.prime_ticks) begin
						phase_d  = PHASE_WAIT;
						stable_d = 8'd0;
						lock_d   = 16'd0;
						bad_d    = 8'd0;
						expect_d = 16'd0;
						ev       = EV_PRIME_DONE;
					end
				end
				PHASE_WAIT: begin
					if (good) begin
						if (stable_q < cfg.stable_checks_needed)
							stable_d = stable_q + 8'd1;
					end else begin
						stable_d = 8'd0;
					end
					if (stable_d >= cfg.stable_checks_needed) begin
						if (expect_q == 16'd0)
							expect_d = wc;
						phase_d = PHASE_LOCK;
						lock_d  = 16'd0;
						bad_d   = 8'd0;
						ev      = EV_STABLE;
					end
				end
				PHASE_LOCK: begin
					if (good) begin
						if (lock_q != 16'hFFFF)
							lock_d = lock_q + 16'd1;
						if (lock_d >= cfg.lock_delay_checks) begin
							phase_d  = PHASE_RUN;
							motion_d = 1'b1;
							bad_d    = 8'd0;
							ev       = EV_LOCKED;
						end
					end else begin
						phase_d  = PHASE_WAIT;
						stable_d = 8'd0;
						lock_d   = 16'd0;
						bad_d    = 8'd0;
						motion_d = 1'b0;
						ev       = EV_LOCK_LOST;
					end
				end
				PHASE_RUN: begin
					if (!ops) begin
						phase_d  = PHASE_WAIT;
						stable_d = 8'd0;
						lock_d   = 16'd0;
						bad_d    = 8'd0;
						motion_d = 1'b0;
						ev       = EV_RUN_LOST;
					end else if (!cnt_good) begin
						if (bad_q != 8'hFF)
							bad_d = bad_q + 8'd1;
						if (bad_d >= cfg.bad_count_limit) begin
							phase_d  = PHASE_WAIT;
							stable_d = 8'd0;
							lock_d   = 16'd0;
							bad_d    = 8'd0;
							motion_d = 1'b0;
							ev       = EV_RUN_BAD;
						end
					end else begin
						bad_d = 8'd0;
					end
				end
				default: ;
			endcase
		end

		res.phase_now     = phase_d;
		res.motion_active = motion_d && (phase_d == PHASE_RUN);
		res.sync_pulse    = pulse;
		res.check_tick    = check;
		res.locked_count  = expect_d;
		res.event_code    = ev;
	end

endmodule

// ----- design/fieldbus_link_phase_supervisor.sv -----
// Top level of the fieldbus link phase supervisor.
// Depends on flps_pkg, flps_regs and flps_core.
//
// channel  | dir | tdata fields (low bit first)                       | width
// s_axis   | in  | all_slaves_op, wkc, zero pad                       | 24
// m_axis   | out | phase_now, motion_active, sync_pulse, check_tick,  | 24
//          |     | locked_count, event_code                           |
// apb      | in  | eight registers at byte address 4*index            | 32
//
// One tick per clock unless m_axis stalls; ticks pass the input, then the result register.
// Tick input register feeds the core logic; its state updates as the result register loads.
// The input stage holds one transaction while the result waits, so a stalled
// output still takes one more tick before s_axis_tready drops.
// Reset restores config, valid flags and core state, and the phase machine to prime phase.
module fieldbus_link_phase_supervisor
	import flps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [0] all_slaves_op, [16:1] wkc
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [1:0] phase_now, [2] motion_active, [3] sync_pulse,
	                                    // [4] check_tick, [20:5] locked_count, [23:21] event_code
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t        cfg;
	result_t     res;
	result_t     res_q;
	logic        valid_s1, valid_q, advance;
	logic        ops_s1;
	logic [15:0] wc_s1;

	flps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	flps_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.ops     (ops_s1),
		.wc      (wc_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign advance       = valid_s1 && (!valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {res_q.event_code, res_q.locked_count, res_q.check_tick,
		res_q.sync_pulse, res_q.motion_active, res_q.phase_now};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				valid_q <= 1'b1;
			else if (m_axis_tready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ops_s1 <= s_axis_tdata[0];
			wc_s1  <= s_axis_tdata[16:1];
		end
		if (advance)
			res_q <= res;
	end

endmodule
